// ===== hw/rtl/cwk_pkg.sv =====
// ----------------------------------------------------------------------------
// Shaped CW tone keyer package
// Sizes, register indexes, period and output codes, and the cosine and
// raised-cosine envelope tables built at elaboration.
// ----------------------------------------------------------------------------
package cwk_pkg;

  // Sizes
  localparam int ShapeLen    = 32;
  localparam int CosDepth    = 256;
  localparam int SampleWidth = 16;

  localparam int CosIdxW  = $clog2(CosDepth);
  localparam int EnvIdxW  = $clog2(ShapeLen);
  localparam int EnvW     = 16;
  localparam int PhaseW   = 32;
  localparam int SymLenW  = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam int EnvDen   = 2 * ShapeLen;

  // Register reset values
  localparam logic [PhaseW-1:0]  PhaseStepRst = 32'd536870912;
  localparam logic [SymLenW-1:0] SymbolLenRst = 16'd480;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgPhaseStep = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSymbolLen = 2'd1;

  // Period kinds: {previous key, key}
  localparam logic [1:0] KindHeldUp   = 2'd0;
  localparam logic [1:0] KindGoDown   = 2'd1;
  localparam logic [1:0] KindGoUp     = 2'd2;
  localparam logic [1:0] KindHeldDown = 2'd3;

  // What the output stage does with a sample
  typedef enum logic [1:0] {
    ModeSilent,
    ModeFull,
    ModeShaped
  } mode_e;

  // Payload between the input stage and the output stage
  typedef struct packed {
    mode_e              mode;
    logic [CosIdxW-1:0] cos_idx;
    logic [EnvW-1:0]    env;
    logic               dot_end;
  } s1_t;

  typedef logic signed [SampleWidth-1:0] cos_rom_t [CosDepth];
  typedef logic [EnvW-1:0]               env_rom_t [ShapeLen];

  localparam longint Q30One = 64'sd1073741824;
  localparam longint AmpMax = (64'sd1 <<< (SampleWidth - 1)) - 64'sd1;

  // Taylor coefficients of cos(pi/2 * y) in powers of y^2, Q30
  localparam longint CosPoly [8] = '{
    64'sd1073741824, -64'sd1324675880, 64'sd272375560, -64'sd22401996,
    64'sd987048, -64'sd27060, 64'sd506, -64'sd7
  };

  // Evaluate the quarter-wave polynomial at y (Q30, 0..1), clamp to 0..1
  function automatic longint cos_poly_q30(longint y);
    longint z;
    longint acc;
    int     k;
    z   = (y * y) >>> 30;
    acc = CosPoly[7];
    for (k = 6; k >= 0; k--) begin
      acc = CosPoly[k] + (acc * z) / Q30One;
    end
    if (acc < 0) acc = 0;
    if (acc > Q30One) acc = Q30One;
    return acc;
  endfunction

  // cos(2*pi*k/CosDepth) in Q30
  function automatic longint cos_tab_q30(int k);
    longint p;
    longint q;
    longint quad;
    longint r;
    longint yn;
    longint y;
    longint acc;
    p    = longint'(k) % CosDepth;
    q    = 4 * p;
    quad = q / CosDepth;
    r    = q % CosDepth;
    yn   = quad[0] ? (CosDepth - r) : r;
    y    = (yn <<< 30) / CosDepth;
    acc  = cos_poly_q30(y);
    return (quad == 1 || quad == 2) ? -acc : acc;
  endfunction

  // cos(2*pi*k/EnvDen) in Q30
  function automatic longint env_cos_q30(int k);
    longint p;
    longint q;
    longint quad;
    longint r;
    longint yn;
    longint y;
    longint acc;
    p    = longint'(k) % EnvDen;
    q    = 4 * p;
    quad = q / EnvDen;
    r    = q % EnvDen;
    yn   = quad[0] ? (EnvDen - r) : r;
    y    = (yn <<< 30) / EnvDen;
    acc  = cos_poly_q30(y);
    return (quad == 1 || quad == 2) ? -acc : acc;
  endfunction

  // Cosine table scaled to full sample amplitude, rounded half away from zero
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    longint   c;
    longint   mag;
    longint   m;
    for (int i = 0; i < CosDepth; i++) begin
      c      = cos_tab_q30(i);
      mag    = (c < 0) ? -c : c;
      m      = (mag * AmpMax + (64'sd1 <<< 29)) >>> 30;
      rom[i] = SampleWidth'((c < 0) ? -m : m);
    end
    return rom;
  endfunction

  // Raised-cosine rise, Q0.16, saturated at the top
  function automatic env_rom_t build_env_rom();
    env_rom_t rom;
    longint   c;
    longint   e;
    for (int i = 0; i < ShapeLen; i++) begin
      c = env_cos_q30(i + 1);
      e = (Q30One - c + 64'sd16384) >>> 15;
      if (e > 64'sd65535) e = 64'sd65535;
      rom[i] = EnvW'(e);
    end
    return rom;
  endfunction

  localparam cos_rom_t CosRom = build_cos_rom();
  localparam env_rom_t EnvRom = build_env_rom();

endpackage

// ===== hw/rtl/shaped_cw_tone_keyer_unit.sv =====
// ----------------------------------------------------------------------------
// Shaped CW tone keyer
// Keyed cosine oscillator with raised-cosine rise and fall on key changes.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_axis channel is one sample tick; bit 0 of tdata is
//   the key level for the current dot period (1 = down), latched on the first
//   tick of a period. Each tick yields one transfer on m_axis: tdata is the
//   signed Q1.15 audio sample, tlast marks the last sample of a dot period.
//   The cfg channel writes phase_step (index 0) and symbol_len (index 1) and
//   is always ready; write it only while no samples are in flight.
// Throughput and pipeline:
//   One tick per cycle while m_axis is not stalled. A taken tick passes
//   through the stages in order: the first stage updates the period counter
//   and phase accumulator, the second does the cosine lookup and the envelope
//   multiply. The phase accumulator and the period counter are feedback loops.
// Reset:
//   Clears key history, period position and phase, loads phase_step with
//   2^29 and symbol_len with 480, and empties both stages.
// Stall:
//   When m_axis_tready_i is low the output sample holds, the first stage
//   keeps one more tick, and then s_axis_tready_o drops until the output
//   is taken.
// ----------------------------------------------------------------------------
module shaped_cw_tone_keyer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Tick input
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [7:0]                          s_axis_tdata_i,   // [0] key
  // Sample output
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [cwk_pkg::SampleWidth-1:0]     m_axis_tdata_o,   // [15:0] sample
  output logic                                m_axis_tlast_o,   // dot_end
  // Register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cwk_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [cwk_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int SW    = cwk_pkg::SampleWidth;
  localparam int ProdW = SW - 1 + cwk_pkg::EnvW;

  // Configuration registers
  logic [cwk_pkg::PhaseW-1:0]  phase_step_q;
  logic [cwk_pkg::SymLenW-1:0] symbol_len_q;

  // Keying state
  logic                        prev_key_q;
  logic [1:0]                  kind_q;
  logic [cwk_pkg::SymLenW-1:0] pos_q;
  logic [cwk_pkg::PhaseW-1:0]  phase_q;

  // Pipeline
  logic                        s1_valid_q;
  cwk_pkg::s1_t                s1_q;
  cwk_pkg::s1_t                s1_d;
  logic                        out_valid_q;
  logic signed [SW-1:0]        sample_q;
  logic signed [SW-1:0]        sample_d;
  logic                        last_q;

  logic out_load;
  logic s1_adv;
  logic s_accept;

  // Stage 1 signals
  logic                        key;
  logic [1:0]                  kind_cur;
  logic                        in_shape;
  logic [cwk_pkg::EnvIdxW-1:0] rise_idx;
  logic [cwk_pkg::EnvIdxW-1:0] fall_idx;
  logic                        tone_on;
  logic [cwk_pkg::PhaseW-1:0]  phase_next;
  logic [cwk_pkg::SymLenW-1:0] len_eff;
  logic [cwk_pkg::SymLenW:0]   pos_inc;
  logic                        dot_end;
  logic [cwk_pkg::SymLenW-1:0] pos_d;

  // Stage 2 signals
  logic signed [SW-1:0]        tone;
  logic                        tone_neg;
  logic [SW-1:0]               tone_abs;
  logic [ProdW-1:0]            prod;
  logic [ProdW:0]              prod_rnd;
  logic [SW-1:0]               shaped_mag;
  logic signed [SW-1:0]        shaped;

  // Register writes, always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= cwk_pkg::PhaseStepRst;
      symbol_len_q <= cwk_pkg::SymbolLenRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == cwk_pkg::CfgPhaseStep) begin
        phase_step_q <= cfg_data_i[cwk_pkg::PhaseW-1:0];
      end else if (cfg_index_i == cwk_pkg::CfgSymbolLen) begin
        symbol_len_q <= cfg_data_i[cwk_pkg::SymLenW-1:0];
      end
    end
  end

  // Handshake: output register loads when empty or drained
  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign s1_adv          = !s1_valid_q || out_load;
  assign s_axis_tready_o = s1_adv;
  assign s_accept        = s_axis_tvalid_i && s1_adv;

  // Stage 1: latch the period kind, pick the envelope, step the phase
  assign key      = s_axis_tdata_i[0];
  assign kind_cur = (pos_q == '0) ? {prev_key_q, key} : kind_q;
  assign in_shape = pos_q < cwk_pkg::SymLenW'(cwk_pkg::ShapeLen);
  assign rise_idx = pos_q[cwk_pkg::EnvIdxW-1:0];
  assign fall_idx = cwk_pkg::EnvIdxW'(cwk_pkg::SymLenW'(cwk_pkg::ShapeLen - 1) - pos_q);

  always_comb begin
    s1_d.cos_idx = phase_next[cwk_pkg::PhaseW-1 -: cwk_pkg::CosIdxW];
    s1_d.dot_end = dot_end;
    s1_d.mode    = cwk_pkg::ModeSilent;
    s1_d.env     = cwk_pkg::EnvRom[rise_idx];
    unique case (kind_cur)
      cwk_pkg::KindHeldUp: begin
        s1_d.mode = cwk_pkg::ModeSilent;
      end
      cwk_pkg::KindGoDown: begin
        s1_d.mode = in_shape ? cwk_pkg::ModeShaped : cwk_pkg::ModeFull;
      end
      cwk_pkg::KindGoUp: begin
        s1_d.mode = in_shape ? cwk_pkg::ModeShaped : cwk_pkg::ModeSilent;
        s1_d.env  = cwk_pkg::EnvRom[fall_idx];
      end
      cwk_pkg::KindHeldDown: begin
        s1_d.mode = cwk_pkg::ModeFull;
      end
      default: begin
        s1_d.mode = cwk_pkg::ModeSilent;
      end
    endcase
  end

  assign tone_on      = s1_d.mode != cwk_pkg::ModeSilent;
  assign phase_next   = phase_q + phase_step_q;

  // Period counter; a zero length acts as one
  assign len_eff      = (symbol_len_q == '0) ? cwk_pkg::SymLenW'(1) : symbol_len_q;
  assign pos_inc      = {1'b0, pos_q} + (cwk_pkg::SymLenW + 1)'(1);
  assign dot_end      = pos_inc >= {1'b0, len_eff};
  assign pos_d        = dot_end ? '0 : pos_inc[cwk_pkg::SymLenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_key_q <= 1'b0;
      kind_q     <= cwk_pkg::KindHeldUp;
      pos_q      <= '0;
      phase_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= s_accept;
      end
      if (s_accept) begin
        kind_q <= kind_cur;
        pos_q  <= pos_d;
        if (pos_q == '0) begin
          prev_key_q <= key;
        end
        if (tone_on) begin
          phase_q <= phase_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: cosine lookup, envelope multiply with rounding on the magnitude
  assign tone       = cwk_pkg::CosRom[s1_q.cos_idx];
  assign tone_neg   = tone[SW-1];
  assign tone_abs   = tone_neg ? SW'(-tone) : SW'(tone);
  assign prod       = tone_abs[SW-2:0] * s1_q.env;
  assign prod_rnd   = {1'b0, prod} + (ProdW + 1)'(1 << (cwk_pkg::EnvW - 1));
  assign shaped_mag = prod_rnd[ProdW -: SW];
  assign shaped     = tone_neg ? -$signed(shaped_mag) : $signed(shaped_mag);

  always_comb begin
    unique case (s1_q.mode)
      cwk_pkg::ModeFull:   sample_d = tone;
      cwk_pkg::ModeShaped: sample_d = shaped;
      default:             sample_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      sample_q <= sample_d;
      last_q   <= s1_q.dot_end;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = sample_q;
  assign m_axis_tlast_o  = last_q;

  // A silent tick leaves the phase where it was
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !tone_on) |=> $stable(phase_q))
    else $error("phase moved on a silent tick");

  // The tick after a period end starts a new period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && dot_end) |=> (pos_q == '0))
    else $error("period position not cleared after dot end");

  // A silent sample leaves the output stage as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_load && s1_q.mode == cwk_pkg::ModeSilent)
      |=> (m_axis_tvalid_o && m_axis_tdata_o == '0))
    else $error("silent sample not zero");

endmodule

// ===== bench/shaped_cw_tone_keyer_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shaped CW tone keyer testbench
// Feeds key ticks and register writes to the keyer. An in-bench keyer
// predictor works out every audio sample, and each sample is checked against
// it. A short directed list covers reset, the register extremes, the four
// period kinds, zero and short periods, and ignored or overwide writes.
// Random periods with random key levels, gaps and stalls follow.
// ----------------------------------------------------------------------------
module shaped_cw_tone_keyer_unit_tb;
  import cwk_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 10;
  localparam int RandItems   = 400;
  localparam int DrainCycles = 4;
  localparam int TailCycles  = 8;
  localparam int StuckLimit  = 4000;

  localparam int LutIdxW = $clog2(CosDepth);

  localparam logic [PhaseW-1:0]  StepAtReset = 32'd536870912;
  localparam logic [SymLenW-1:0] LenAtReset  = 16'd480;

  // Indexes past the register list; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare3 = 2'd3;

  localparam logic signed [SampleWidth-1:0] Silence   = '0;
  localparam logic signed [SampleWidth-1:0] FullScale = 16'sd32767;

  localparam longint Q30Unit = 64'sd1073741824;
  localparam longint ToneAmp = (64'sd1 <<< (SampleWidth - 1)) - 64'sd1;

  // cos(pi/2 * y) as a series in y^2, Q30
  localparam longint PolyQ30 [8] = '{
    64'sd1073741824, -64'sd1324675880, 64'sd272375560, -64'sd22401996,
    64'sd987048, -64'sd27060, 64'sd506, -64'sd7
  };

  typedef struct packed {
    logic signed [SampleWidth-1:0] sample;
    logic                          dot_end;
  } keyer_out_t;

  typedef enum logic {
    RowTick,
    RowWrite
  } row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic [CfgIdxW-1:0]            idx;
    logic [CfgDataW-1:0]           data;
    logic                          key;
    logic                          typed;
    logic signed [SampleWidth-1:0] exp_sample;
    logic                          exp_end;
  } stim_row_t;

  localparam int NumRows = 32;
  localparam stim_row_t Directed [NumRows] = '{
    // reset defaults: held up, long period
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b0, 1'b1, Silence,   1'b0},
    '{RowWrite, CfgPhaseStep, 32'h0,         1'b0, 1'b0, Silence,   1'b0},
    // zero length mid-period: ends the open period at once
    '{RowWrite, CfgSymbolLen, 32'h0,         1'b0, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b1, 1'b1, Silence,   1'b1},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b1, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b1, 1'b1, FullScale, 1'b1},
    '{RowWrite, CfgPhaseStep, 32'hFFFF_FFFF, 1'b0, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b1, 1'b0, Silence,   1'b0},
    '{RowWrite, CfgPhaseStep, 32'h8000_0000, 1'b0, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b0, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b0, 1'b1, Silence,   1'b1},
    // writes past the list, then an overwide length
    '{RowWrite, CfgSpare2,    32'hFFFF_FFFF, 1'b0, 1'b0, Silence,   1'b0},
    '{RowWrite, CfgSpare3,    32'h1234_5678, 1'b0, 1'b0, Silence,   1'b0},
    '{RowWrite, CfgSymbolLen, 32'hFFFF_0005, 1'b0, 1'b0, Silence,   1'b0},
    // short periods: rise and fall cut off at the period end
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b1, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b1, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b1, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b1, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b1, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b0, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b0, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b0, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b0, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b0, 1'b0, Silence,   1'b0},
    '{RowWrite, CfgSymbolLen, 32'h1,         1'b0, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b1, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b0, 1'b0, Silence,   1'b0},
    // longest period, smallest step; later keys in a period are ignored
    '{RowWrite, CfgSymbolLen, 32'h0000_FFFF, 1'b0, 1'b0, Silence,   1'b0},
    '{RowWrite, CfgPhaseStep, 32'h1,         1'b0, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b1, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b0, 1'b0, Silence,   1'b0},
    '{RowTick,  CfgPhaseStep, 32'h0,         1'b0, 1'b0, Silence,   1'b0}
  };

  logic                        clk_i     = 1'b0;
  logic                        rst_ni    = 1'b0;
  logic                        s_tvalid  = 1'b0;
  logic [7:0]                  s_tdata   = '0;
  logic                        m_tready  = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]          cfg_index = '0;
  logic [CfgDataW-1:0]         cfg_data  = '0;
  logic                        s_axis_tready_o;
  logic                        m_axis_tvalid_o;
  logic [SampleWidth-1:0]      m_axis_tdata_o;
  logic                        m_axis_tlast_o;
  logic                        cfg_ready_o;

  // Predictor tables and state
  logic signed [SampleWidth-1:0] tone_lut  [CosDepth];
  logic [EnvW-1:0]               shape_lut [ShapeLen];
  logic [PhaseW-1:0]             step_reg;
  logic [SymLenW-1:0]            len_reg;
  logic                          key_hist;
  logic [1:0]                    kind_now;
  logic [SymLenW-1:0]            pos_now;
  logic [PhaseW-1:0]             phase_acc;

  keyer_out_t pending_samples [$];
  keyer_out_t head;

  int  errors      = 0;
  int  n_ticks     = 0;
  int  n_writes    = 0;
  int  n_checked   = 0;
  int  n_ends      = 0;
  int  stuck       = 0;
  int  quiet_left  = 0;
  int  stall_left  = 0;
  int  sink_roll;
  bit  src_steady  = 1'b0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  shaped_cw_tone_keyer_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // cos(2*pi*num/den) in Q30 from the quarter-wave series
  function automatic longint cos_q30_of(input longint num, input longint den);
    longint p;
    longint q;
    longint quad;
    longint r;
    longint yn;
    longint y;
    longint z;
    longint acc;
    p    = num % den;
    q    = 4 * p;
    quad = q / den;
    r    = q % den;
    yn   = quad[0] ? (den - r) : r;
    y    = (yn <<< 30) / den;
    z    = (y * y) >>> 30;
    acc  = PolyQ30[7];
    for (int k = 6; k >= 0; k--) begin
      acc = PolyQ30[k] + (acc * z) / Q30Unit;
    end
    if (acc < 0) acc = 0;
    if (acc > Q30Unit) acc = Q30Unit;
    return (quad == 1 || quad == 2) ? -acc : acc;
  endfunction

  // Scale tone by a Q0.16 gain, round half away from zero on the magnitude
  function automatic logic signed [SampleWidth-1:0] shape_tone(
      input logic signed [SampleWidth-1:0] tone, input logic [EnvW-1:0] gain);
    longint mag;
    longint m;
    mag = (tone < 0) ? -longint'(tone) : longint'(tone);
    m   = (mag * longint'(gain) + 64'sd32768) >>> 16;
    return SampleWidth'((tone < 0) ? -m : m);
  endfunction

  // Advance the phase, then look up the new phase
  function automatic logic signed [SampleWidth-1:0] advance_tone();
    phase_acc = phase_acc + step_reg;
    return tone_lut[phase_acc[PhaseW-1 -: LutIdxW]];
  endfunction

  // Work out the audio sample for one key tick and update the keyer state
  function automatic keyer_out_t next_audio_sample(input logic key);
    keyer_out_t res;
    int         len_eff;
    len_eff = (len_reg == 0) ? 1 : int'(len_reg);
    res     = '0;
    if (pos_now == 0) begin
      kind_now = {key_hist, key};
      key_hist = key;
    end
    case (kind_now)
      KindGoDown: begin
        if (pos_now < ShapeLen) res.sample = shape_tone(advance_tone(), shape_lut[pos_now]);
        else                    res.sample = advance_tone();
      end
      KindGoUp: begin
        if (pos_now < ShapeLen)
          res.sample = shape_tone(advance_tone(), shape_lut[ShapeLen - 1 - pos_now]);
      end
      KindHeldDown: begin
        res.sample = advance_tone();
      end
      default: begin
        res.sample = Silence;
      end
    endcase
    res.dot_end = (int'(pos_now) + 1 >= len_eff);
    pos_now     = res.dot_end ? '0 : pos_now + 1'b1;
    return res;
  endfunction

  // Source gap length: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    if (src_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  // Hand one key tick to the keyer and queue its predicted sample
  task automatic send_tick(input logic key, input bit use_typed, input keyer_out_t typed_val);
    int         gap;
    keyer_out_t want;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, key};
    do @(posedge clk_i); while (!s_axis_tready_o);
    want = next_audio_sample(key);
    if (use_typed) want = typed_val;
    pending_samples.push_back(want);
    n_ticks++;
  endtask

  // Write a register once every queued sample has come out
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    s_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CfgPhaseStep: step_reg = data;
      CfgSymbolLen: len_reg  = data[SymLenW-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // Sink: random stalls, mostly short, some long, with quiet stretches
  always @(posedge clk_i) begin
    if (quiet_left > 0) begin
      m_tready   <= 1'b1;
      quiet_left <= quiet_left - 1;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 4) begin
        quiet_left <= $urandom_range(30, 150);
        m_tready   <= 1'b1;
      end else if (sink_roll < 18) begin
        stall_left <= $urandom_range(0, 2);
        m_tready   <= 1'b0;
      end else if (sink_roll < 21) begin
        stall_left <= $urandom_range(8, 40);
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Check each sample transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample %0d last %0b", $time,
                 $signed(m_axis_tdata_o), m_axis_tlast_o);
        errors++;
      end else begin
        head = pending_samples.pop_front();
        if ($signed(m_axis_tdata_o) !== head.sample) begin
          $display("%0t: sample mismatch: expected %0d, got %0d", $time,
                   head.sample, $signed(m_axis_tdata_o));
          errors++;
        end
        if (m_axis_tlast_o !== head.dot_end) begin
          $display("%0t: dot end mismatch: expected %0b, got %0b", $time,
                   head.dot_end, m_axis_tlast_o);
          errors++;
        end
        if (head.dot_end) n_ends++;
        n_checked++;
      end
    end
  end

  // Count cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) ||
        (cfg_valid && cfg_ready_o)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin : watchdog
    while (stuck < StuckLimit) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles", $time, StuckLimit);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stim
    longint     c;
    longint     mag;
    longint     m;
    longint     e;
    keyer_out_t typed_val;
    int         n_rand;
    int         items;
    int         mix;
    logic [CfgDataW-1:0] wdata;
    logic       period_key;
    logic       noisy;
    logic       key;

    // Build the predictor's cosine and envelope tables
    for (int i = 0; i < CosDepth; i++) begin
      c   = cos_q30_of(i, CosDepth);
      mag = (c < 0) ? -c : c;
      m   = (mag * ToneAmp + (64'sd1 <<< 29)) >>> 30;
      tone_lut[i] = SampleWidth'((c < 0) ? -m : m);
    end
    for (int i = 0; i < ShapeLen; i++) begin
      c = cos_q30_of(i + 1, 2 * ShapeLen);
      e = (Q30Unit - c + 64'sd16384) >>> 15;
      shape_lut[i] = (e > 64'sd65535) ? 16'hFFFF : EnvW'(e);
    end
    step_reg   = StepAtReset;
    len_reg    = LenAtReset;
    key_hist   = 1'b0;
    kind_now   = KindHeldUp;
    pos_now    = '0;
    phase_acc  = '0;
    period_key = 1'b0;
    noisy      = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed list
    for (int r = 0; r < NumRows; r++) begin
      if (Directed[r].kind == RowWrite) begin
        write_reg(Directed[r].idx, Directed[r].data);
      end else begin
        typed_val.sample  = Directed[r].exp_sample;
        typed_val.dot_end = Directed[r].exp_end;
        send_tick(Directed[r].key, Directed[r].typed, typed_val);
      end
    end

    // Random phases: new settings, then periods of random key level
    n_rand = 0;
    while (n_rand < RandItems) begin
      mix = $urandom_range(0, 3);
      if (mix != 2) begin
        case ($urandom_range(0, 5))
          0:       wdata = 32'h0;
          1:       wdata = 32'hFFFF_FFFF;
          2:       wdata = $urandom_range(1, 255);
          3:       wdata = {8'($urandom_range(0, 255)), 24'h0};
          default: wdata = $urandom();
        endcase
        write_reg(CfgPhaseStep, wdata);
      end
      if (mix != 1) begin
        wdata = $urandom_range(0, 1) ? $urandom() : 32'h0;
        case ($urandom_range(0, 9))
          0:       wdata[15:0] = 16'd0;
          1:       wdata[15:0] = 16'($urandom_range(1, 31));
          2:       wdata[15:0] = 16'd32;
          3:       wdata[15:0] = 16'd33;
          4:       wdata[15:0] = 16'hFFFF;
          default: wdata[15:0] = 16'($urandom_range(34, 72));
        endcase
        write_reg(CfgSymbolLen, wdata);
      end
      if (mix == 3) begin
        write_reg($urandom_range(0, 1) ? CfgSpare2 : CfgSpare3, $urandom());
      end
      src_steady = ($urandom_range(0, 3) == 0);
      items      = $urandom_range(20, 60);
      for (int i = 0; i < items; i++) begin
        // pick a level per period; now and then a period with a ragged key
        if (pos_now == 0) begin
          noisy      = ($urandom_range(0, 7) == 0);
          period_key = $urandom_range(0, 1);
        end
        key = noisy ? 1'($urandom_range(0, 1)) : period_key;
        send_tick(key, 1'b0, '0);
        n_rand++;
      end
    end

    // Drain and settle
    s_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d key ticks (%0d random) and %0d register writes", n_ticks, n_rand,
             n_writes);
    $display("Checked %0d samples, %0d period ends, %0d mismatches", n_checked, n_ends,
             errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
